### hdl/sptst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sptst_pkg
// Shared types and constants of the patch/timbre sysex tracker.
// ----------------------------------------------------------------------------
package sptst_pkg;

    // Item kinds carried in the low bits of the input tuser
    localparam logic [1:0] OP_PATCH  = 2'd0;
    localparam logic [1:0] OP_TIMBRE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Fixed field widths
    localparam int DATA_W   = 8;
    localparam int LEN_W    = 12;
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 96;
    localparam int OUT_CHARS = 10;

    // Message layout
    localparam int ADDR_HI_POS = 5;
    localparam int ADDR_LO_POS = 6;
    localparam int BODY_POS    = 7;
    localparam int RECORD_TAIL = 9;
    localparam int PROG_BANK   = 64;

    // Controller to datapath commands
    typedef struct packed {
        logic msg_en;     // message byte transfer, update position and tables
        logic msg_patch;  // message byte belongs to a patch message
        logic qry_en;     // query transfer, read both stores
        logic out_load;   // load the result register from the read data
    } sptst_cmd_t;

endpackage : sptst_pkg
`default_nettype wire

### hdl/synth_patch_timbre_sysex_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// A message byte is absorbed in its transfer cycle; a query result reaches
//   m_tdata through the registered table read and then the result register,
//   and is held back only while a previous result is still unread.
// Message bytes are taken one per cycle while no query is in lookup; a query
//   holds the input side until its result is loaded into the result register.
// Reset: asynchronous, active low; tables read their power-up values at once
//   through per-entry and per-row valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
// synth_patch_timbre_sysex_tracker
// Tracks patch-memory and timbre-memory sysex messages fed one byte per
// transfer and answers queries for a patch's group/program and a timbre name.
// ----------------------------------------------------------------------------
module synth_patch_timbre_sysex_tracker
    import sptst_pkg::*;
#(
    parameter int PATCH_ENTRIES     = 128,
    parameter int NAME_SLOTS        = 64,
    parameter int NAME_CHARS        = 10,
    parameter int MAX_MESSAGE_BYTES = 4096
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [7:0] data_byte, [19:8] message_length, [27:20] query_program,
    // [35:28] query_memory, [39:36] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [1:0] operation, [2] start_of_message
    input  wire logic [S_USER_W-1:0] s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [7:0] patch_group, [15:8] patch_program, [79:16] name_first_eight,
    // [95:80] name_last_two
    output logic      [M_DATA_W-1:0] m_tdata
);

    sptst_cmd_t cmd;

    // Controller: accepts one transfer at a time. Patch and timbre bytes are
    // consumed in the transfer cycle; a query holds the input side in the lookup
    // state and waits there until the result register is free.
    sptst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: byte position counter, record address and held group of the
    // patch parser, selected name slot, the patch table, the name store and
    // the result register that drives m_tdata.
    sptst_dp #(
        .PATCH_ENTRIES     (PATCH_ENTRIES),
        .NAME_SLOTS        (NAME_SLOTS),
        .NAME_CHARS        (NAME_CHARS),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .start_of_message (s_tuser[2]),
        .data_byte        (s_tdata[7:0]),
        .message_length   (s_tdata[19:8]),
        .query_program    (s_tdata[27:20]),
        .query_memory     (s_tdata[35:28]),
        .result           (m_tdata)
    );

endmodule : synth_patch_timbre_sysex_tracker
`default_nettype wire

### hdl/sptst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sptst_ctrl
// Handshake controller: issues datapath commands and owns the output valid.
// ----------------------------------------------------------------------------
module sptst_ctrl
    import sptst_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_USER_W-1:0] s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output sptst_cmd_t               cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic [1:0] op;

    assign op       = s_tuser[1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd.msg_en    = 1'b0;
        cmd.msg_patch = (op == OP_PATCH);
        cmd.qry_en    = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (op) inside
                        OP_PATCH, OP_TIMBRE:
                        begin
                            cmd.msg_en = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            cmd.qry_en = 1'b1;
                            state_next = ST_LOOKUP;
                        end
                        default:
                        begin
                            // drop unused code
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // A query transfer always moves on to the lookup cycle
    a_query_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && op == OP_QUERY) |=> (state_reg == ST_LOOKUP))
        else $error("query transfer did not start a lookup");

    // Never overwrite a result that is still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // A result appears only after a lookup
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result shown without a lookup");

    // Message bytes finish in their transfer cycle
    a_msg_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.msg_en |=> (state_reg == ST_IDLE))
        else $error("message byte left the controller busy");

endmodule : sptst_ctrl
`default_nettype wire

### hdl/sptst_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sptst_dp
// Datapath: message parser registers, patch table, name store, result format.
// ----------------------------------------------------------------------------
module sptst_dp
    import sptst_pkg::*;
#(
    parameter int PATCH_ENTRIES     = 128,
    parameter int NAME_SLOTS        = 64,
    parameter int NAME_CHARS        = 10,
    parameter int MAX_MESSAGE_BYTES = 4096
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sptst_cmd_t          cmd,
    input  wire logic                start_of_message,
    input  wire logic [DATA_W-1:0]   data_byte,
    input  wire logic [LEN_W-1:0]    message_length,
    input  wire logic [7:0]          query_program,
    input  wire logic [7:0]          query_memory,
    output logic      [M_DATA_W-1:0] result
);

    localparam int POS_W  = $clog2(MAX_MESSAGE_BYTES);
    localparam int PIDX_W = $clog2(PATCH_ENTRIES);
    localparam int SLOT_W = $clog2(NAME_SLOTS);
    localparam int CH_W   = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
    localparam int CMP_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES - 1);

    // parser state
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      rec_addr_reg;
    logic [15:0]      rec_addr_next;
    logic [7:0]       held_group_reg;
    logic [7:0]       held_group_next;
    logic [6:0]       slot_reg;
    logic [6:0]       slot_next;

    // stores
    logic [15:0]     ptab_mem [PATCH_ENTRIES];
    logic [PATCH_ENTRIES-1:0] pvalid_reg;
    logic [7:0]      name_mem [NAME_SLOTS][NAME_CHARS];
    logic [NAME_SLOTS-1:0]    nvalid_reg;

    // read side
    logic [15:0]     ptab_rd_reg;
    logic            pvld_rd_reg;
    logic [PIDX_W-1:0] pidx_rd_reg;
    logic [7:0]      name_rd_reg [NAME_CHARS];
    logic            nvld_rd_reg;
    logic [M_DATA_W-1:0] result_reg;
    logic [M_DATA_W-1:0] result_next;

    logic [POS_W-1:0] pos;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] len_x;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] chi;
    logic             ge_body;
    logic             rec_hold;
    logic             rec_write;
    logic             patch_in_range;
    logic             ptab_we;
    logic [PIDX_W-1:0] ptab_waddr;
    logic [7:0]       prog_wdata;
    logic             slot_ok;
    logic             name_we;
    logic [SLOT_W-1:0] name_row;
    logic [CH_W-1:0]  name_ch;
    logic             name_fill;
    logic             name_clear;
    logic [6:0]       new_slot;
    logic [11:0]      qmod;
    logic [PIDX_W-1:0] qidx;
    logic             qslot_ok;

    assign pos   = start_of_message ? '0 : pos_reg;
    assign pos_x = CMP_W'(pos);
    assign len_x = CMP_W'(message_length);
    assign limit = len_x - CMP_W'(RECORD_TAIL);
    assign chi   = pos_x - CMP_W'(BODY_POS);
    assign ge_body = (pos_x >= CMP_W'(BODY_POS));

    // record boundaries: group at offset 0, program at offset 1
    assign rec_hold  = ge_body && (len_x > CMP_W'(RECORD_TAIL)) && (pos[2:0] == 3'd7)
                       && (pos_x < limit);
    assign rec_write = ge_body && (len_x > CMP_W'(RECORD_TAIL)) && (pos[2:0] == 3'd0)
                       && ((pos_x - CMP_W'(1)) < limit);
    assign patch_in_range = (rec_addr_reg[15:3] < 13'(PATCH_ENTRIES));
    assign ptab_waddr = rec_addr_reg[3 +: PIDX_W];
    assign prog_wdata = (held_group_reg == 8'd1) ? (data_byte + 8'(PROG_BANK)) : data_byte;
    assign ptab_we    = cmd.msg_en && cmd.msg_patch && rec_write && patch_in_range;

    // timbre name handling
    assign new_slot   = data_byte[7:1];
    assign slot_ok    = (8'(slot_reg) < 8'(NAME_SLOTS));
    assign name_row   = slot_reg[SLOT_W-1:0];
    assign name_ch    = chi[CH_W-1:0];
    assign name_we    = cmd.msg_en && !cmd.msg_patch && ge_body && (pos_x < len_x)
                        && (chi < CMP_W'(NAME_CHARS)) && slot_ok;
    assign name_fill  = !nvalid_reg[name_row];
    assign name_clear = cmd.msg_en && !cmd.msg_patch && (pos_x == CMP_W'(ADDR_HI_POS))
                        && (len_x > CMP_W'(BODY_POS)) && (8'(new_slot) < 8'(NAME_SLOTS));

    // query index modulo the table size by restoring subtraction
    always_comb
    begin
        qmod = 12'(query_program);
        for (int k = 3; k >= 0; k--)
        begin
            if (qmod >= 12'(PATCH_ENTRIES << k))
                qmod = qmod - 12'(PATCH_ENTRIES << k);
        end
        qidx = qmod[PIDX_W-1:0];
    end
    assign qslot_ok = (query_memory < 8'(NAME_SLOTS));

    // parser next state
    always_comb
    begin
        pos_next        = pos_reg;
        rec_addr_next   = rec_addr_reg;
        held_group_next = held_group_reg;
        slot_next       = slot_reg;
        if (cmd.msg_en)
        begin
            pos_next = (pos < POS_MAX) ? (pos + POS_W'(1)) : POS_MAX;
            if (cmd.msg_patch)
            begin
                if (pos_x == CMP_W'(ADDR_HI_POS))
                    rec_addr_next = {1'b0, data_byte, 7'd0};
                else if (pos_x == CMP_W'(ADDR_LO_POS))
                    rec_addr_next = rec_addr_reg | {8'd0, data_byte};
                else if (rec_hold)
                    held_group_next = data_byte;
                else if (rec_write)
                    rec_addr_next = rec_addr_reg + 16'd8;
            end
            else if (pos_x == CMP_W'(ADDR_HI_POS))
            begin
                slot_next = new_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            rec_addr_reg   <= '0;
            held_group_reg <= '0;
            slot_reg       <= '0;
            pvalid_reg     <= '0;
            nvalid_reg     <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            rec_addr_reg   <= rec_addr_next;
            held_group_reg <= held_group_next;
            slot_reg       <= slot_next;
            if (ptab_we)
                pvalid_reg[ptab_waddr] <= 1'b1;
            if (name_clear)
                nvalid_reg[new_slot[SLOT_W-1:0]] <= 1'b0;
            else if (name_we)
                nvalid_reg[name_row] <= 1'b1;
        end
    end

    // patch table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ptab_we)
            ptab_mem[ptab_waddr] <= {prog_wdata, held_group_reg};
        if (cmd.qry_en)
        begin
            ptab_rd_reg <= ptab_mem[qidx];
            pvld_rd_reg <= pvalid_reg[qidx];
            pidx_rd_reg <= qidx;
        end
    end

    // name store: row write with byte enables, a row not yet valid gets zero fill
    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            for (int c = 0; c < NAME_CHARS; c++)
            begin
                if (CH_W'(c) == name_ch)
                    name_mem[name_row][c] <= data_byte;
                else if (name_fill)
                    name_mem[name_row][c] <= 8'd0;
            end
        end
        if (cmd.qry_en)
        begin
            name_rd_reg <= name_mem[query_memory[SLOT_W-1:0]];
            nvld_rd_reg <= qslot_ok && nvalid_reg[query_memory[SLOT_W-1:0]];
        end
    end

    // result format: name stops at its first zero character
    always_comb
    begin
        logic       alive;
        logic [7:0] ch;
        alive = 1'b1;
        result_next = '0;
        result_next[7:0]  = pvld_rd_reg ? ptab_rd_reg[7:0]
                          : ((8'(pidx_rd_reg) < 8'(PROG_BANK)) ? 8'd0 : 8'd1);
        result_next[15:8] = pvld_rd_reg ? ptab_rd_reg[15:8] : 8'(pidx_rd_reg);
        for (int c = 0; c < OUT_CHARS; c++)
        begin
            ch = 8'd0;
            if (c < NAME_CHARS && nvld_rd_reg)
                ch = name_rd_reg[c];
            if (ch == 8'd0)
                alive = 1'b0;
            result_next[16 + 8*c +: 8] = alive ? ch : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule : sptst_dp
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the patch/timbre sysex tracker. Patch and timbre
// message bytes and queries are streamed into the block while a behavioral
// model of the patch table, name store and position counter predicts each
// query reply; replies are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import sptst_pkg::*;

    localparam int PATCH_COUNT    = 128;
    localparam int SLOT_COUNT     = 64;
    localparam int CHARS_PER_NAME = 10;
    localparam int POS_LIMIT      = 4095;  // position counter saturates here
    localparam int RANDOM_ITEMS   = 450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = 16;

    // Reply layout, identical to m_tdata; members run from the top bit downward
    typedef struct packed {
        logic [15:0] name_hi;
        logic [63:0] name_lo;
        logic [7:0]  patch_prog;
        logic [7:0]  patch_grp;
    } patch_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    wire                 s_tready;
    // [7:0] data_byte, [19:8] message_length, [27:20] query_program,
    // [35:28] query_memory, [39:36] zero
    logic [S_DATA_W-1:0] s_tdata = '0;
    // [1:0] operation, [2] start_of_message
    logic [S_USER_W-1:0] s_tuser = '0;
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    // [7:0] patch_group, [15:8] patch_program, [79:16] name_first_eight,
    // [95:80] name_last_two
    wire  [M_DATA_W-1:0] m_tdata;

    // Model state: patch tables, name store and message parser registers
    bit [7:0]     grp_tbl [PATCH_COUNT];
    bit [7:0]     prg_tbl [PATCH_COUNT];
    bit [7:0]     name_mem [SLOT_COUNT*CHARS_PER_NAME];
    int unsigned  msg_pos;
    bit [15:0]    rec_addr;
    bit [7:0]     held_grp;
    bit [7:0]     slot_sel;

    patch_reply_t pending_replies[$];
    int           mismatches = 0;
    int           items_sent = 0;
    int           idle_cycles = 0;
    int           hold_left = 0;
    bit           pace_on = 1'b0;

    synth_patch_timbre_sysex_tracker #(
        .PATCH_ENTRIES     (PATCH_COUNT),
        .NAME_SLOTS        (SLOT_COUNT),
        .NAME_CHARS        (CHARS_PER_NAME),
        .MAX_MESSAGE_BYTES (POS_LIMIT + 1)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Gap length for both sides: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Advance the model by one accepted transfer; queue a reply for a query
    function automatic void track_item(logic [1:0] op, bit som, bit [7:0] data,
                                       bit [11:0] len, bit [7:0] qprog, bit [7:0] qmem);
        int unsigned  pos;
        int unsigned  span;
        int unsigned  patch;
        bit           ended;
        bit [7:0]     ch;
        patch_reply_t reply;
        case (op)
            OP_PATCH, OP_TIMBRE:
            begin
                pos = som ? 0 : msg_pos;
                if (op == OP_PATCH)
                begin
                    if (pos == ADDR_HI_POS)
                        rec_addr = {1'b0, data, 7'b0};
                    else if (pos == ADDR_LO_POS)
                        rec_addr = rec_addr | {8'b0, data};
                    else if (pos >= BODY_POS && len > RECORD_TAIL)
                    begin
                        // A record opens with its group byte, then the program byte
                        if ((pos - BODY_POS) % 8 == 0 && pos < len - RECORD_TAIL)
                            held_grp = data;
                        else if ((pos - BODY_POS) % 8 == 1 && pos - 1 < len - RECORD_TAIL)
                        begin
                            patch = rec_addr >> 3;
                            if (patch < PATCH_COUNT)
                            begin
                                grp_tbl[patch] = held_grp;
                                prg_tbl[patch] = (held_grp == 8'd1) ?
                                                 8'(data + PROG_BANK) : data;
                            end
                            rec_addr = rec_addr + 16'd8;
                        end
                    end
                end
                else
                begin
                    if (pos == ADDR_HI_POS)
                    begin
                        // Select the slot and wipe it when a name can follow
                        slot_sel = data >> 1;
                        if (len > BODY_POS && slot_sel < SLOT_COUNT)
                            for (int i = 0; i < CHARS_PER_NAME; i++)
                                name_mem[slot_sel*CHARS_PER_NAME + i] = 8'd0;
                    end
                    else if (pos >= BODY_POS && len > BODY_POS && slot_sel < SLOT_COUNT)
                    begin
                        span = len - BODY_POS;
                        if (span > CHARS_PER_NAME)
                            span = CHARS_PER_NAME;
                        if (pos - BODY_POS < span)
                            name_mem[slot_sel*CHARS_PER_NAME + pos - BODY_POS] = data;
                    end
                end
                msg_pos = (pos < POS_LIMIT) ? pos + 1 : POS_LIMIT;
            end
            OP_QUERY:
            begin
                reply = '0;
                reply.patch_grp  = grp_tbl[qprog[6:0]];
                reply.patch_prog = prg_tbl[qprog[6:0]];
                // The name stops at its first zero character
                if (qmem < SLOT_COUNT)
                begin
                    ended = 1'b0;
                    for (int i = 0; i < OUT_CHARS; i++)
                    begin
                        ch = name_mem[qmem*CHARS_PER_NAME + i];
                        if (ch == 8'd0)
                            ended = 1'b1;
                        if (!ended && i < 8)
                            reply.name_lo[8*i +: 8] = ch;
                        else if (!ended)
                            reply.name_hi[8*(i-8) +: 8] = ch;
                    end
                end
                pending_replies.push_back(reply);
            end
            default:
            begin
                // unused operation code: no state change, no reply
            end
        endcase
    endfunction

    // Drive one input transfer; entered and left at a falling edge
    task automatic send_item(input logic [1:0] op, input bit som, input bit [7:0] data,
                             input bit [11:0] len, input bit [7:0] qprog,
                             input bit [7:0] qmem);
        int gap;
        gap = pace_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  <= {som, op};
        s_tdata  <= {4'b0, qmem, qprog, len, data};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        track_item(op, som, data, len, qprog, qmem);
        if (op != OP_NONE)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_query(input bit [7:0] qprog, input bit [7:0] qmem);
        send_item(OP_QUERY, 1'($urandom), 8'($urandom), 12'($urandom), qprog, qmem);
    endtask

    // Stream a message; optionally interleave queries and vary the length field
    task automatic feed_message(input logic [1:0] op, input bit [11:0] len,
                                input bit [7:0] body[$], input int query_odds,
                                input bit jitter);
        bit [11:0] item_len;
        foreach (body[i])
        begin
            if (query_odds > 0 && $urandom_range(1, query_odds) == 1)
                send_query(8'($urandom), 8'($urandom_range(0, 70)));
            item_len = jitter ? 12'($urandom_range(0, 40)) : len;
            send_item(op, i == 0, body[i], item_len, 8'($urandom), 8'($urandom));
        end
    endtask

    // Power-up contents of the tables and the extremes of the query fields
    task automatic test_reset_state();
        send_query(8'd0, 8'd0);
        send_query(8'd255, 8'd255);
        send_query(8'd64, 8'd64);
    endtask

    // One group-1 record into the last patch; the program byte wraps past 255
    task automatic test_patch_record();
        bit [7:0] body[$];
        send_item(OP_NONE, 1'b1, 8'hFF, 12'hFFF, 8'hFF, 8'hFF);
        body = '{8'hF0, 8'h41, 8'h10, 8'h16, 8'h12, 8'h07, 8'h78, 8'h01, 8'hC8};
        feed_message(OP_PATCH, 12'd17, body, 0, 1'b0);
        send_query(8'd127, 8'd0);
    endtask

    // Name with an embedded zero: everything from the zero on reads as zero
    task automatic test_timbre_name();
        bit [7:0] body[$];
        body = '{8'hF0, 8'h41, 8'h10, 8'h16, 8'h12, 8'h7F, 8'h00, 8'h41, 8'h00, 8'h43};
        feed_message(OP_TIMBRE, 12'd10, body, 0, 1'b0);
        send_query(8'd0, 8'd63);
    endtask

    // Mostly well-formed patch and timbre messages with random content,
    // mixed with query bursts and stray transfers of any kind
    task automatic test_random_traffic();
        bit [7:0]    body[$];
        bit [11:0]   len;
        int unsigned pick;
        int unsigned nbytes;
        bit [15:0]   addr;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            pace_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            body = {};
            if (pick < 40)
            begin
                len = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 16)) :
                                                    12'($urandom_range(17, 48));
                nbytes = (len > 9) ? len : $urandom_range(1, 12);
                for (int i = 0; i < nbytes; i++)
                begin
                    if (i == 0)
                        body.push_back(8'hF0);
                    else if (i == ADDR_HI_POS)
                        body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                                                    8'($urandom_range(0, 7)));
                    else if (i >= BODY_POS && (i - BODY_POS) % 8 == 0)
                        body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                                                    8'($urandom_range(0, 1)));
                    else
                        body.push_back(8'($urandom));
                end
                feed_message(OP_PATCH, len, body, 20, $urandom_range(0, 9) == 0);
                addr = (nbytes > ADDR_LO_POS) ?
                       ({1'b0, body[ADDR_HI_POS], 7'b0} | {8'b0, body[ADDR_LO_POS]}) : '0;
                send_query(($urandom_range(0, 1) == 0) ? addr[10:3] : 8'($urandom),
                           8'($urandom));
            end
            else if (pick < 70)
            begin
                len = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 7)) :
                                                    12'($urandom_range(8, 22));
                nbytes = (len > 7) ? len + $urandom_range(0, 2) : $urandom_range(1, 10);
                for (int i = 0; i < nbytes; i++)
                begin
                    if (i == 0)
                        body.push_back(8'hF0);
                    else if (i == ADDR_HI_POS)
                        body.push_back(($urandom_range(0, 5) == 0) ?
                                       8'($urandom_range(128, 255)) :
                                       8'($urandom_range(0, 127)));
                    else if (i >= BODY_POS)
                        body.push_back(($urandom_range(0, 7) == 0) ? 8'd0 :
                                       8'($urandom_range(1, 255)));
                    else
                        body.push_back(8'($urandom));
                end
                feed_message(OP_TIMBRE, len, body, 20, $urandom_range(0, 9) == 0);
                send_query(8'($urandom),
                           (nbytes > ADDR_HI_POS) ? body[ADDR_HI_POS] >> 1 : 8'($urandom));
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4))
                    send_query(8'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                             8'($urandom_range(0, 63)));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_item(2'($urandom), 1'($urandom), 8'($urandom), 12'($urandom),
                              8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Receiver side: hold off tready for random stretches while pacing is on
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (pace_on && $urandom_range(0, 3) == 0)
                hold_left <= pick_gap();
        end
    end

    // Compare each reply transfer against the oldest predicted reply
    always @(posedge clk)
    begin
        patch_reply_t want;
        patch_reply_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = patch_reply_t'(m_tdata);
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected reply %h", m_tdata);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (want !== got)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        if (want.patch_grp !== got.patch_grp)
                            $display("patch_group: expected %h got %h",
                                     want.patch_grp, got.patch_grp);
                        if (want.patch_prog !== got.patch_prog)
                            $display("patch_program: expected %h got %h",
                                     want.patch_prog, got.patch_prog);
                        if (want.name_lo !== got.name_lo)
                            $display("name_first_eight: expected %h got %h",
                                     want.name_lo, got.name_lo);
                        if (want.name_hi !== got.name_hi)
                            $display("name_last_two: expected %h got %h",
                                     want.name_hi, got.name_hi);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        // Model power-up state
        for (int i = 0; i < PATCH_COUNT; i++)
        begin
            grp_tbl[i] = (i < 64) ? 8'd0 : 8'd1;
            prg_tbl[i] = 8'(i);
        end
        foreach (name_mem[i])
            name_mem[i] = 8'd0;
        msg_pos  = 0;
        rec_addr = '0;
        held_grp = '0;
        slot_sel = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_patch_record();
        test_timbre_name();
        test_random_traffic();

        // Drop valid, let the receiver run freely and drain outstanding replies
        s_tvalid <= 1'b0;
        pace_on = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
